>>> rtl/core/mme_pkg.sv
// mme_pkg: shared types and constants of the montgomery modular exponentiation unit
// payload structs for both channels and the control word of the shared arithmetic unit
// depends on nothing
`timescale 1ns / 1ps

package mme_pkg;

    localparam int unsigned MME_WIDTH = 32;
    localparam int unsigned MME_CNT_W = $clog2(MME_WIDTH + 1);
    localparam logic [MME_WIDTH-1:0] MME_MODULUS_RST = MME_WIDTH'(3233);

    typedef struct packed {
        logic [MME_WIDTH-1:0] base;
        logic [MME_WIDTH-1:0] exponent;
    } mme_in_t;

    typedef struct packed {
        logic [MME_WIDTH-1:0] power;
        logic                 bad_modulus;
    } mme_out_t;

    typedef enum logic {
        MME_OP_REDUCE,
        MME_OP_MONT
    } mme_op_t;

    typedef struct packed {
        mme_op_t op;
        logic    xbit;
        logic    inbit;
    } mme_alu_ctrl_t;

endpackage

>>> rtl/core/mme_alu.sv
// mme_alu: shared add and compare-subtract unit, one step per cycle
// reduce step (2*acc + bit) mod n, or one bit of a montgomery product
// depends on mme_pkg
`timescale 1ns / 1ps

module mme_alu (
    input  mme_pkg::mme_alu_ctrl_t        ctrl,
    input  logic [mme_pkg::MME_WIDTH-1:0] modulus,
    input  logic [mme_pkg::MME_WIDTH-1:0] acc,
    input  logic [mme_pkg::MME_WIDTH-1:0] y,
    output logic [mme_pkg::MME_WIDTH-1:0] res
);

    localparam int unsigned W = mme_pkg::MME_WIDTH;

    logic [W-1:0] addend;
    logic [W-1:0] corr;
    logic         q;
    logic [W+1:0] sum;
    logic [W:0]   pre;
    logic [W:0]   diff;

    always_comb begin
        addend = ctrl.xbit ? y : '0;
        q      = acc[0] ^ (ctrl.xbit & y[0]);
        corr   = q ? modulus : '0;
        sum    = (W+2)'(acc) + (W+2)'(addend) + (W+2)'(corr);
        unique case (ctrl.op)
            mme_pkg::MME_OP_REDUCE: pre = {acc, ctrl.inbit};
            mme_pkg::MME_OP_MONT:   pre = sum[W+1:1];
            default:                pre = '0;
        endcase
        diff = pre - {1'b0, modulus};
        res  = (pre >= {1'b0, modulus}) ? diff[W-1:0] : pre[W-1:0];
    end

endmodule

>>> rtl/core/montgomery_mod_exp_unit.sv
// montgomery_mod_exp_unit: base^exponent mod modulus by bit-serial montgomery products
// top level with sequencer, operand registers and modulus register
// depends on mme_pkg and mme_alu
`timescale 1ns / 1ps

// One word in gives one word out: power = base^(exponent mod 2^m) mod modulus, where m is the
// bit length of the modulus register. The unit takes one word at a time; s_ready stays low
// until the result has been handed to the output register, which holds it while the next
// word is already accepted. The bit length m is found by shifting a copy of the modulus;
// then R^2 mod n, the reduced base and 3 + m + k montgomery products (k = set bits among
// the low m exponent bits) are worked out in one shared add/compare-subtract unit at one
// bit per cycle. An even modulus or one below 3 returns power 0 with bad_modulus set and
// skips these steps. The modulus may only be written while the unit is idle.

module montgomery_mod_exp_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [mme_pkg::MME_WIDTH-1:0] cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  mme_pkg::mme_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output mme_pkg::mme_out_t             m_data
);

    localparam int unsigned W  = mme_pkg::MME_WIDTH;
    localparam int unsigned CW = mme_pkg::MME_CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_R2,
        ST_MODA,
        ST_LOAD,
        ST_MONT,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        PR_Z0,
        PR_P0,
        PR_MUL,
        PR_SQR,
        PR_FIN
    } prod_t;

    state_t             state_reg, state_next;
    prod_t              prod_reg, prod_next;
    logic [W-1:0]       modulus_reg, modulus_next;
    logic [W-1:0]       len_reg, len_next;
    logic [CW-1:0]      m_reg, m_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      ecnt_reg, ecnt_next;
    logic [W-1:0]       base_reg, base_next;
    logic [W-1:0]       exp_reg, exp_next;
    logic [W-1:0]       acc_reg, acc_next;
    logic [W-1:0]       x_reg, x_next;
    logic [W-1:0]       y_reg, y_next;
    logic [W-1:0]       r_reg, r_next;
    logic [W-1:0]       z_reg, z_next;
    logic [W-1:0]       p_reg, p_next;
    mme_pkg::mme_out_t  res_reg, res_next;
    mme_pkg::mme_out_t  m_data_reg, m_data_next;
    logic               m_valid_reg, m_valid_next;

    mme_pkg::mme_alu_ctrl_t alu_ctrl;
    logic [W-1:0]           alu_res;
    logic [W-1:0]           mmask;
    logic [CW-1:0]          m_last;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign mmask  = ~({W{1'b1}} << m_reg);
    assign m_last = m_reg - CW'(1);

    always_comb begin
        alu_ctrl.op    = (state_reg == ST_MONT) ? mme_pkg::MME_OP_MONT : mme_pkg::MME_OP_REDUCE;
        alu_ctrl.xbit  = x_reg[0];
        alu_ctrl.inbit = (state_reg == ST_MODA) ? base_reg[W-1] : 1'b0;
    end

    mme_alu u_alu (
        .ctrl    (alu_ctrl),
        .modulus (modulus_reg),
        .acc     (acc_reg),
        .y       (y_reg),
        .res     (alu_res)
    );

    always_comb begin
        state_next   = state_reg;
        prod_next    = prod_reg;
        modulus_next = modulus_reg;
        len_next     = len_reg;
        m_next       = m_reg;
        cnt_next     = cnt_reg;
        ecnt_next    = ecnt_reg;
        base_next    = base_reg;
        exp_next     = exp_reg;
        acc_next     = acc_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        r_next       = r_reg;
        z_next       = z_reg;
        p_next       = p_reg;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;

        if (cfg_wr_en) begin
            modulus_next = cfg_wr_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    base_next = s_data.base;
                    exp_next  = s_data.exponent;
                    len_next  = modulus_reg;
                    m_next    = '0;
                    if ((modulus_reg < W'(3)) || !modulus_reg[0]) begin
                        res_next.power       = '0;
                        res_next.bad_modulus = 1'b1;
                        state_next           = ST_DONE;
                    end else begin
                        state_next = ST_LEN;
                    end
                end
            end
            ST_LEN: begin
                if (len_reg != '0) begin
                    len_next = len_reg >> 1;
                    m_next   = m_reg + CW'(1);
                end else begin
                    // R mod n is 2^m - n
                    acc_next   = (~modulus_reg + W'(1)) & mmask;
                    cnt_next   = '0;
                    state_next = ST_R2;
                end
            end
            ST_R2: begin
                acc_next = alu_res;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == m_last) begin
                    r_next     = alu_res;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_MODA;
                end
            end
            ST_MODA: begin
                acc_next  = alu_res;
                base_next = base_reg << 1;
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(W - 1)) begin
                    p_next     = alu_res;
                    prod_next  = PR_Z0;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                acc_next   = '0;
                cnt_next   = '0;
                state_next = ST_MONT;
                case (prod_reg)
                    PR_Z0: begin
                        x_next = W'(1);
                        y_next = r_reg;
                    end
                    PR_P0: begin
                        x_next = p_reg;
                        y_next = r_reg;
                    end
                    PR_MUL: begin
                        x_next = z_reg;
                        y_next = p_reg;
                    end
                    PR_SQR: begin
                        x_next = p_reg;
                        y_next = p_reg;
                    end
                    default: begin
                        x_next = W'(1);
                        y_next = z_reg;
                    end
                endcase
            end
            ST_MONT: begin
                acc_next = alu_res;
                x_next   = x_reg >> 1;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == m_last) begin
                    state_next = ST_LOAD;
                    case (prod_reg)
                        PR_Z0: begin
                            z_next    = alu_res;
                            prod_next = PR_P0;
                        end
                        PR_P0: begin
                            p_next    = alu_res;
                            ecnt_next = '0;
                            prod_next = exp_reg[0] ? PR_MUL : PR_SQR;
                        end
                        PR_MUL: begin
                            z_next    = alu_res;
                            prod_next = PR_SQR;
                        end
                        PR_SQR: begin
                            p_next    = alu_res;
                            exp_next  = exp_reg >> 1;
                            ecnt_next = ecnt_reg + CW'(1);
                            if (ecnt_reg == m_last) begin
                                prod_next = PR_FIN;
                            end else begin
                                prod_next = exp_reg[1] ? PR_MUL : PR_SQR;
                            end
                        end
                        default: begin
                            res_next.power       = alu_res;
                            res_next.bad_modulus = 1'b0;
                            state_next           = ST_DONE;
                        end
                    endcase
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            modulus_reg <= mme_pkg::MME_MODULUS_RST;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            modulus_reg <= modulus_next;
        end
        prod_reg   <= prod_next;
        len_reg    <= len_next;
        m_reg      <= m_next;
        cnt_reg    <= cnt_next;
        ecnt_reg   <= ecnt_next;
        base_reg   <= base_next;
        exp_reg    <= exp_next;
        acc_reg    <= acc_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        r_reg      <= r_next;
        z_reg      <= z_next;
        p_reg      <= p_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    // one word in flight: no second accept right after an accept
    a_single_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a word is in flight");

    // output register only loads from the result stage
    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_DONE))
        else $error("result word raised outside the result stage");

    // montgomery accumulator stays reduced
    a_acc_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MONT) |-> (acc_reg < modulus_reg))
        else $error("accumulator not below modulus");

    // a bad modulus always comes with a zero power
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.bad_modulus) |-> (m_data.power == '0))
        else $error("bad modulus with nonzero power");

endmodule
